/* rtl/qtg_pkg.sv */
// shared types and constants for the quality tier governor
package qtg_pkg;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_REPORT  = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_DISABLE = 2'd3
  } qtg_cmd_t;

  typedef struct packed {
    qtg_cmd_t    command;
    logic [17:0] latency;
    logic        accepted;
  } qtg_in_t;

  typedef struct packed {
    logic        tier_fast;
    logic        probing;
    logic [17:0] average_latency;
    logic        average_valid;
    logic [9:0]  reprobe_wait;
  } qtg_out_t;

  localparam int unsigned LAT_W = 18;
  localparam int unsigned IVL_W = 10;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_SAMPLES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_INTERVAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL   = 3'd4;

  // register reset values
  localparam logic [LAT_W-1:0] RST_LATENCY_LIMIT  = 18'd8704;
  localparam logic [CNT_W-1:0] RST_MIN_SAMPLES    = 8'd10;
  localparam logic [CNT_W-1:0] RST_STABLE_SAMPLES = 8'd30;
  localparam logic [IVL_W-1:0] RST_BASE_INTERVAL  = 10'd60;
  localparam logic [IVL_W-1:0] RST_MAX_INTERVAL   = 10'd600;

  localparam logic [CNT_W-1:0] CNT_MAX   = 8'd255;
  localparam logic [IVL_W-1:0] DWELL_MAX = 10'd1023;

  // divide by five: q = (x * ceil(2^23 / 5)) >> 23, exact for x < 2^21
  localparam int unsigned        SUM_W      = 21;
  localparam int unsigned        DIV5_SHIFT = 23;
  localparam logic [SUM_W-1:0]   DIV5_RECIP = 21'd1677722;

endpackage

/* rtl/quality_tier_governor_backoff.sv */
// quality tier governor: latency average, tier drop and reprobe backoff
//
// usage:
//   in_* carries one command item (request, report, tick, disable) under
//   valid/ready. every item yields exactly one out_* item under valid/ready
//   holding the tier, probe flag, moving average and reprobe interval as
//   they stand after that item.
//   cfg_* writes a register; write only while the block is idle.
// timing:
//   an item is registered on acceptance; its result is loaded into the
//   output stage once that stage is free and shown on out_* from then on.
//   one item per cycle is sustained while out_ready is high: the governor
//   state updates in the same cycle that the result is loaded, so the next
//   item sees it; the average's divide-by-five multiply and threshold compare set the path.
// reset:
//   rst_n low clears both stages, restores register defaults and returns
//   the governor to balanced with no samples and the base interval.
// stall:
//   when out_ready is low the result holds; one more item can still be
//   accepted into the input stage, after which in_ready drops.
module quality_tier_governor_backoff (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  qtg_pkg::qtg_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output qtg_pkg::qtg_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [qtg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qtg_pkg::LAT_W-1:0]           cfg_wdata
);
  import qtg_pkg::*;

  // configuration
  logic [LAT_W-1:0] latency_limit_r;
  logic [CNT_W-1:0] min_samples_r;
  logic [CNT_W-1:0] stable_samples_r;
  logic [IVL_W-1:0] base_interval_r;
  logic [IVL_W-1:0] max_interval_r;

  // pipeline
  logic     s1_valid_r;
  qtg_in_t  s1_r;
  logic     out_valid_r;
  qtg_out_t out_r;
  qtg_out_t out_nxt;
  logic     advance;

  // governor state
  logic             tier_fast_r,  tier_fast_nxt;
  logic [LAT_W-1:0] avg_r,        avg_nxt;
  logic             avg_has_r,    avg_has_nxt;
  logic [CNT_W-1:0] count_r,      count_nxt;
  logic             probe_r,      probe_nxt;
  logic [IVL_W-1:0] wait_r,       wait_nxt;
  logic [IVL_W-1:0] dwell_r,      dwell_nxt;

  // report datapath
  logic [SUM_W-1:0]       avg_sum;
  logic [2*SUM_W-1:0]     avg_prod;
  logic [LAT_W-1:0]       avg_div;
  logic [LAT_W-1:0]       rep_avg;
  logic [CNT_W-1:0]       rep_count;
  logic                   rep_drop;
  logic [IVL_W:0]         wait_dbl;
  logic [IVL_W-1:0]       wait_capped;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latency_limit_r  <= RST_LATENCY_LIMIT;
      min_samples_r    <= RST_MIN_SAMPLES;
      stable_samples_r <= RST_STABLE_SAMPLES;
      base_interval_r  <= RST_BASE_INTERVAL;
      max_interval_r   <= RST_MAX_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LATENCY_LIMIT:  latency_limit_r  <= cfg_wdata;
        CFG_MIN_SAMPLES:    min_samples_r    <= cfg_wdata[CNT_W-1:0];
        CFG_STABLE_SAMPLES: stable_samples_r <= cfg_wdata[CNT_W-1:0];
        CFG_BASE_INTERVAL:  base_interval_r  <= cfg_wdata[IVL_W-1:0];
        CFG_MAX_INTERVAL:   max_interval_r   <= cfg_wdata[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // (lat + 4*avg + 2) / 5 by reciprocal multiply
  assign avg_sum  = {3'b000, s1_r.latency} + {1'b0, avg_r, 2'b00} + SUM_W'(2);
  assign avg_prod = (2*SUM_W)'(avg_sum) * (2*SUM_W)'(DIV5_RECIP);
  assign avg_div  = avg_prod[DIV5_SHIFT +: LAT_W];

  assign rep_avg   = avg_has_r ? avg_div : s1_r.latency;
  assign rep_count = (count_r != CNT_MAX) ? count_r + CNT_W'(1) : count_r;
  assign rep_drop  = (rep_count >= min_samples_r) && (rep_avg > latency_limit_r);

  assign wait_dbl    = {wait_r, 1'b0};
  assign wait_capped = (wait_dbl < {1'b0, max_interval_r}) ? wait_dbl[IVL_W-1:0]
                                                           : max_interval_r;

  always_comb begin
    tier_fast_nxt = tier_fast_r;
    avg_nxt       = avg_r;
    avg_has_nxt   = avg_has_r;
    count_nxt     = count_r;
    probe_nxt     = probe_r;
    wait_nxt      = wait_r;
    dwell_nxt     = dwell_r;
    if (advance) begin
      case (s1_r.command)
        CMD_REQUEST: begin
          // reprobe: back to balanced with a fresh average
          if (tier_fast_r && (dwell_r >= wait_r)) begin
            tier_fast_nxt = 1'b0;
            avg_nxt       = '0;
            avg_has_nxt   = 1'b0;
            count_nxt     = '0;
            probe_nxt     = 1'b1;
          end
        end
        CMD_REPORT: begin
          if (s1_r.accepted) begin
            avg_nxt     = rep_avg;
            avg_has_nxt = 1'b1;
            count_nxt   = rep_count;
            if (rep_drop) begin
              tier_fast_nxt = 1'b1;
              dwell_nxt     = '0;
              if (probe_r) begin
                wait_nxt = wait_capped;
              end
              probe_nxt = 1'b0;
            end else if (probe_r && (rep_count >= stable_samples_r)) begin
              wait_nxt  = base_interval_r;
              probe_nxt = 1'b0;
            end
          end
        end
        CMD_TICK: begin
          if (dwell_r != DWELL_MAX) begin
            dwell_nxt = dwell_r + IVL_W'(1);
          end
        end
        default: begin
          tier_fast_nxt = 1'b0;
          avg_nxt       = '0;
          avg_has_nxt   = 1'b0;
          count_nxt     = '0;
          probe_nxt     = 1'b0;
          wait_nxt      = base_interval_r;
          dwell_nxt     = '0;
        end
      endcase
    end
  end

  always_comb begin
    out_nxt.tier_fast       = tier_fast_nxt;
    out_nxt.probing         = probe_nxt;
    out_nxt.average_latency = avg_has_nxt ? avg_nxt : '0;
    out_nxt.average_valid   = avg_has_nxt;
    out_nxt.reprobe_wait    = wait_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tier_fast_r <= 1'b0;
      avg_r       <= '0;
      avg_has_r   <= 1'b0;
      count_r     <= '0;
      probe_r     <= 1'b0;
      wait_r      <= RST_BASE_INTERVAL;
      dwell_r     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      tier_fast_r <= tier_fast_nxt;
      avg_r       <= avg_nxt;
      avg_has_r   <= avg_has_nxt;
      count_r     <= count_nxt;
      probe_r     <= probe_nxt;
      wait_r      <= wait_nxt;
      dwell_r     <= dwell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* rtl/qtg_checker.sv */
// port-level checker for the quality tier governor, bound to the top level
module qtg_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input qtg_pkg::qtg_out_t out_data
);
  import qtg_pkg::*;

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // with the output stage empty the input side never blocks
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output stage");

  // a probe only runs in the balanced tier
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.tier_fast && out_data.probing))
    else $error("probing while in fast tier");

  // no average shown before a sample is in
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.average_valid |-> out_data.average_latency == '0)
    else $error("average shown without a sample");

  // reset empties the output stage
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present after reset");

endmodule

bind quality_tier_governor_backoff qtg_checker u_qtg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/quality_tier_governor_backoff_test.sv */
// testbench for the quality tier governor: random and directed items checked by a scoreboard
module quality_tier_governor_backoff_test;
  import qtg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [LAT_W-1:0]     LAT_TOP    = 18'h3FFFF;
  localparam logic [SUM_W-1:0]     FIVE       = 21'd5;
  localparam logic [SUM_W-1:0]     HALF_UP    = 21'd2;

  class tier_scoreboard;
    logic [LAT_W-1:0] lat_limit;
    logic [CNT_W-1:0] min_smp;
    logic [CNT_W-1:0] stable_smp;
    logic [IVL_W-1:0] base_ivl;
    logic [IVL_W-1:0] max_ivl;
    logic             fast;
    logic             avg_ok;
    logic             probe;
    logic [LAT_W-1:0] avg;
    logic [CNT_W-1:0] samples;
    logic [IVL_W-1:0] wait_ivl;
    logic [IVL_W-1:0] dwell;
    qtg_out_t         expected_q[$];
    int               errors;

    function new();
      errors = 0;
      lat_limit  = RST_LATENCY_LIMIT;
      min_smp    = RST_MIN_SAMPLES;
      stable_smp = RST_STABLE_SAMPLES;
      base_ivl   = RST_BASE_INTERVAL;
      max_ivl    = RST_MAX_INTERVAL;
      reset_state();
    endfunction

    function void reset_state();
      fast     = 1'b0;
      avg      = '0;
      avg_ok   = 1'b0;
      samples  = '0;
      probe    = 1'b0;
      wait_ivl = base_ivl;
      dwell    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LAT_W-1:0] data);
      case (idx)
        CFG_LATENCY_LIMIT:  lat_limit  = data;
        CFG_MIN_SAMPLES:    min_smp    = data[CNT_W-1:0];
        CFG_STABLE_SAMPLES: stable_smp = data[CNT_W-1:0];
        CFG_BASE_INTERVAL:  base_ivl   = data[IVL_W-1:0];
        CFG_MAX_INTERVAL:   max_ivl    = data[IVL_W-1:0];
        default: ;
      endcase
    endfunction

    function void fold_sample(logic [LAT_W-1:0] lat);
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] quot;
      logic [IVL_W:0]   doubled;
      if (avg_ok) begin
        // weight 1/5, rounded to nearest with halves up
        sum  = {3'b000, lat} + {1'b0, avg, 2'b00} + HALF_UP;
        quot = sum / FIVE;
        avg  = quot[LAT_W-1:0];
      end else begin
        avg    = lat;
        avg_ok = 1'b1;
      end
      if (samples != CNT_MAX) samples = samples + 1'b1;
      if (samples >= min_smp && avg > lat_limit) begin
        fast  = 1'b1;
        dwell = '0;
        if (probe) begin
          // failed probe backs off
          doubled  = {wait_ivl, 1'b0};
          wait_ivl = (doubled < {1'b0, max_ivl}) ? doubled[IVL_W-1:0] : max_ivl;
        end
        probe = 1'b0;
      end else if (probe && samples >= stable_smp) begin
        wait_ivl = base_ivl;
        probe    = 1'b0;
      end
    endfunction

    function void note_item(qtg_in_t item);
      qtg_out_t res;
      case (item.command)
        CMD_REQUEST: begin
          if (fast && dwell >= wait_ivl) begin
            fast    = 1'b0;
            avg     = '0;
            avg_ok  = 1'b0;
            samples = '0;
            probe   = 1'b1;
          end
        end
        CMD_REPORT: begin
          if (item.accepted) fold_sample(item.latency);
        end
        CMD_TICK: begin
          if (dwell != DWELL_MAX) dwell = dwell + 1'b1;
        end
        default: reset_state();
      endcase
      res.tier_fast       = fast;
      res.probing         = probe;
      res.average_latency = avg_ok ? avg : '0;
      res.average_valid   = avg_ok;
      res.reprobe_wait    = wait_ivl;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [LAT_W-1:0] want, logic [LAT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(qtg_out_t got);
      qtg_out_t want;
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("tier_fast", LAT_W'(want.tier_fast), LAT_W'(got.tier_fast));
      compare_field("probing", LAT_W'(want.probing), LAT_W'(got.probing));
      compare_field("average_latency", want.average_latency, got.average_latency);
      compare_field("average_valid", LAT_W'(want.average_valid), LAT_W'(got.average_valid));
      compare_field("reprobe_wait", LAT_W'(want.reprobe_wait), LAT_W'(got.reprobe_wait));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  qtg_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  qtg_out_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LAT_W-1:0]     cfg_wdata = '0;

  tier_scoreboard sb;
  bit             tx_calm  = 1'b0;
  bit             rx_calm  = 1'b0;
  bit             hold_req = 1'b0;
  int             hold_len = 0;

  quality_tier_governor_backoff dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall_left;
    int r;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = hold_len;
      end else if (stall_left == 0 && !rx_calm) begin
        r = int'($urandom_range(0, 99));
        if (r >= 75) stall_left = (r >= 97) ? int'($urandom_range(8, 40)) :
                                              int'($urandom_range(1, 3));
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic qtg_in_t make_item(qtg_cmd_t cmd, logic [LAT_W-1:0] lat, logic acc);
    qtg_in_t item;
    item.command  = cmd;
    item.latency  = lat;
    item.accepted = acc;
    return item;
  endfunction

  function automatic int tx_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (tx_calm || r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(4, 25));
  endfunction

  // report-heavy mode keeps samples piling up without probes clearing them
  function automatic qtg_in_t random_item(bit heavy);
    qtg_in_t          item;
    int               r;
    int               v;
    logic [LAT_W-1:0] noise;
    noise = LAT_W'($urandom);
    r = int'($urandom_range(0, 99));
    if (heavy)
      item.command = (r < 2) ? CMD_REQUEST : (r < 97) ? CMD_REPORT : CMD_TICK;
    else
      item.command = (r < 25) ? CMD_REQUEST : (r < 70) ? CMD_REPORT :
                     (r < 97) ? CMD_TICK : CMD_DISABLE;
    item.accepted = ($urandom_range(0, 99) < 90);
    r = int'($urandom_range(0, 99));
    v = int'(sb.lat_limit);
    if (r < 40) v = v + int'($urandom_range(0, 400)) - 200;
    else if (r < 60) v = int'($urandom_range(0, v));
    else if (r < 85) v = int'($urandom_range(v, LAT_TOP));
    else v = int'(noise);
    if (v < 0) v = 0;
    if (v > int'(LAT_TOP)) v = int'(LAT_TOP);
    item.latency = v[LAT_W-1:0];
    return item;
  endfunction

  task automatic send_item(qtg_in_t item, int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_item(item);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LAT_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper bits beyond a register's width carry junk
  task automatic set_config(logic [LAT_W-1:0] limit, logic [CNT_W-1:0] min_s,
                            logic [CNT_W-1:0] stable_s, logic [IVL_W-1:0] base_i,
                            logic [IVL_W-1:0] max_i);
    logic [LAT_W-1:0] junk;
    junk = LAT_W'($urandom);
    write_reg(CFG_LATENCY_LIMIT, limit);
    write_reg(CFG_MIN_SAMPLES, {junk[17:8], min_s});
    write_reg(CFG_STABLE_SAMPLES, {junk[9:0], stable_s});
    write_reg(CFG_BASE_INTERVAL, {junk[17:10], base_i});
    write_reg(CFG_MAX_INTERVAL, {junk[7:0], max_i});
  endtask

  initial begin : stimulus
    int               n_items;
    logic [LAT_W-1:0] rnd_limit;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register defaults
    send_item(make_item(CMD_REQUEST, '0, 1'b0), 0);
    send_item(make_item(CMD_REPORT, LAT_TOP, 1'b0), 0);
    send_item(make_item(CMD_REPORT, '0, 1'b1), 1);
    send_item(make_item(CMD_REPORT, LAT_TOP, 1'b1), 0);
    send_item(make_item(CMD_TICK, LAT_TOP, 1'b1), 2);
    send_item(make_item(CMD_DISABLE, '0, 1'b0), 0);
    drain_results();

    // drop, early request, failed probes up to the cap, then a stable probe
    set_config(18'd1000, 8'd1, 8'd2, 10'd1, 10'd3);
    write_reg(CFG_UNUSED, LAT_TOP);
    send_item(make_item(CMD_DISABLE, LAT_TOP, 1'b1), 0);
    send_item(make_item(CMD_REPORT, LAT_TOP, 1'b1), 0);
    send_item(make_item(CMD_REQUEST, '0, 1'b0), 0);
    send_item(make_item(CMD_TICK, '0, 1'b0), 0);
    send_item(make_item(CMD_REQUEST, '0, 1'b0), 0);
    send_item(make_item(CMD_REPORT, LAT_TOP, 1'b1), 0);
    repeat (2) send_item(make_item(CMD_TICK, '0, 1'b0), 0);
    send_item(make_item(CMD_REQUEST, '0, 1'b0), 0);
    send_item(make_item(CMD_REPORT, LAT_TOP, 1'b1), 0);
    repeat (3) send_item(make_item(CMD_TICK, '0, 1'b0), 0);
    send_item(make_item(CMD_REQUEST, '0, 1'b0), 0);
    send_item(make_item(CMD_REPORT, '0, 1'b1), 0);
    send_item(make_item(CMD_REPORT, 18'd100, 1'b1), 0);

    for (int ph = 0; ph < 10; ph++) begin
      drain_results();
      tx_calm = (ph % 3 == 1);
      rx_calm = (ph % 4 == 2);
      case (ph)
        0: set_config('0, '0, '0, '0, '0);
        1: set_config(LAT_TOP, 8'd255, 8'd255, 10'd1023, 10'd1023);
        2: set_config(18'd20000, 8'd255, 8'd255, 10'd2, 10'd40);
        default: begin
          rnd_limit = ($urandom_range(0, 99) < 20) ? LAT_TOP & LAT_W'($urandom) :
                      LAT_W'($urandom_range(500, 20000));
          set_config(rnd_limit, CNT_W'($urandom_range(1, 6)), CNT_W'($urandom_range(1, 8)),
                     IVL_W'($urandom_range(1, 6)), IVL_W'($urandom_range(1, 40)));
        end
      endcase
      if ($urandom_range(0, 1) == 1) send_item(make_item(CMD_DISABLE, '0, 1'b0), 0);
      if (ph == 3) begin
        // receiver holds off while items keep coming, so the input backs up
        tx_calm  = 1'b1;
        hold_len = 150;
        hold_req = 1'b1;
      end
      n_items = (ph == 2) ? 350 : 45;
      repeat (n_items) send_item(random_item(ph == 2), tx_gap());
    end

    // dwell timer saturation: with the widest interval a request still probes
    drain_results();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    set_config('0, 8'd1, 8'd255, 10'd1023, 10'd1023);
    send_item(make_item(CMD_DISABLE, '0, 1'b0), 0);
    send_item(make_item(CMD_REPORT, 18'd5, 1'b1), 0);
    repeat (int'(DWELL_MAX) + 4) send_item(make_item(CMD_TICK, LAT_W'($urandom), 1'b0), 0);
    send_item(make_item(CMD_REQUEST, '0, 1'b0), 0);
    send_item(make_item(CMD_REPORT, 18'd7, 1'b1), 0);

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/qtg_pkg.sv
rtl/quality_tier_governor_backoff.sv
rtl/qtg_checker.sv
test/quality_tier_governor_backoff_test.sv
